// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the CSV filler block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cefu_pkg.sv =====
// Types, character codes and sizes for the CSV empty field filler.
package cefu_pkg;

  // Longest run of output bytes one input byte can cause.
  localparam int RUN_MAX = 9;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);
  localparam int PH_LEN  = 6;

  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_X     = 8'd88;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_BREAK  = 3'd1,
    MODE_INVAL  = 3'd2,
    MODE_QUOTED = 3'd3,
    MODE_DQ     = 3'd4
  } mode_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    mode_t mode;
    logic  quote_pending;
    logic  break_after_quote;
  } pstate_t;

  // Output bytes caused by one input byte.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
  } run_t;

endpackage

// ===== sv/cefu_step.sv =====
// Per-byte parser step: next state and the run of output bytes.
module cefu_step (
  input  cefu_pkg::pstate_t st,
  input  logic [7:0]        in_byte,
  output cefu_pkg::pstate_t st_next,
  output cefu_pkg::run_t    run
);
  import cefu_pkg::*;

  always_comb begin
    pstate_t          s;
    run_t             r;
    logic [CNT_W-1:0] cnt;
    logic             hdl;
    s   = st;
    r   = '0;
    cnt = '0;
    hdl = 1'b1;

    // Resolve a held quote against this byte
    if (s.quote_pending) begin
      s.quote_pending = 1'b0;
      if (in_byte == CH_QUOTE && (s.mode == MODE_QUOTED || s.mode == MODE_DQ)) begin
        r.bytes[0] = CH_QUOTE;
        r.bytes[1] = CH_QUOTE;
        cnt = CNT_W'(2);
        s.mode = (s.mode == MODE_QUOTED) ? MODE_DQ : MODE_QUOTED;
        hdl = 1'b0;
      end else if (s.mode == MODE_QUOTED) begin
        r.bytes[0] = CH_QUOTE;
        r.bytes[1] = CH_COMMA;
        cnt = CNT_W'(2);
        s.mode = MODE_BREAK;
        s.break_after_quote = 1'b1;
      end
    end

    // Normal handling of the byte in the current mode
    if (hdl) begin
      case (s.mode)
        MODE_BREAK: begin
          if (in_byte == CH_COMMA) begin
            if (!s.break_after_quote) begin
              for (int k = 0; k < PH_LEN; k++) begin
                r.bytes[cnt] = CH_X;
                cnt = cnt + 1'b1;
              end
              r.bytes[cnt] = CH_COMMA;
              cnt = cnt + 1'b1;
            end
          end else if (in_byte == CH_NL) begin
            for (int k = 0; k < PH_LEN; k++) begin
              r.bytes[cnt] = CH_X;
              cnt = cnt + 1'b1;
            end
            r.bytes[cnt] = CH_NL;
            cnt = cnt + 1'b1;
            s.mode = MODE_START;
          end else begin
            r.bytes[cnt] = in_byte;
            cnt = cnt + 1'b1;
            s.mode = (in_byte == CH_QUOTE) ? MODE_QUOTED : MODE_INVAL;
          end
          s.break_after_quote = 1'b0;
        end
        MODE_INVAL: begin
          if (in_byte == CH_COMMA) begin
            r.bytes[cnt] = in_byte;
            cnt = cnt + 1'b1;
            s.mode = MODE_BREAK;
            s.break_after_quote = 1'b0;
          end else if (in_byte == CH_NL) begin
            r.bytes[cnt] = CH_NL;
            cnt = cnt + 1'b1;
            s.mode = MODE_START;
          end else if (in_byte != CH_QUOTE) begin
            r.bytes[cnt] = in_byte;
            cnt = cnt + 1'b1;
          end
        end
        MODE_QUOTED, MODE_DQ: begin
          // Quotes wait one byte; newlines inside quotes are dropped
          if (in_byte == CH_QUOTE) begin
            s.quote_pending = 1'b1;
          end else if (in_byte != CH_NL) begin
            r.bytes[cnt] = in_byte;
            cnt = cnt + 1'b1;
          end
        end
        default: begin
          // Start of line; unused codes behave the same
          if (in_byte == CH_COMMA) begin
            for (int k = 0; k < PH_LEN; k++) begin
              r.bytes[cnt] = CH_X;
              cnt = cnt + 1'b1;
            end
            r.bytes[cnt] = CH_COMMA;
            cnt = cnt + 1'b1;
            s.mode = MODE_BREAK;
            s.break_after_quote = 1'b0;
          end else if (in_byte == CH_QUOTE) begin
            r.bytes[cnt] = in_byte;
            cnt = cnt + 1'b1;
            s.mode = MODE_QUOTED;
          end else if (in_byte == CH_NL) begin
            r.bytes[cnt] = CH_NL;
            cnt = cnt + 1'b1;
            s.mode = MODE_START;
          end else begin
            r.bytes[cnt] = in_byte;
            cnt = cnt + 1'b1;
            s.mode = MODE_INVAL;
          end
        end
      endcase
    end

    r.count = cnt;
    st_next = s;
    run     = r;
  end

endmodule

// ===== sv/csv_empty_field_filler_unit.sv =====
// Top level: CSV empty field filler with input skid and output run buffer.
// The first output word appears in the cycle after accept if the run buffer is free,
// else the word waits in the skid register until the current run ends.
// Throughput: one output word per cycle unless out_stall; an input word causing n
// output words keeps the run buffer until all are taken; plain text flows alike.
// in_stall is the skid full flag. Synchronous active-high rst: start of line.
module csv_empty_field_filler_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import cefu_pkg::*;
`include "assert_macros.svh"

  pstate_t          st, st_next;
  run_t             run_new;
  logic             skid_valid;
  logic [7:0]       skid_byte;
  logic             buf_valid;
  run_t             run_buf;
  logic [CNT_W-1:0] idx;
  logic             in_fire, out_fire, is_last, buf_free, load_buf;
  logic [7:0]       step_byte;

  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = buf_valid;
  assign out_fire  = out_valid && !out_stall;
  assign is_last   = (idx + 1'b1) == run_buf.count;
  assign out_byte    = run_buf.bytes[idx];
  assign last_of_run = is_last;

  // Run buffer takes a new run when empty or finishing its last word
  assign buf_free  = !buf_valid || (out_fire && is_last);
  assign step_byte = skid_valid ? skid_byte : in_byte;
  assign load_buf  = buf_free && (skid_valid || in_fire);

  cefu_step u_step (
    .st      (st),
    .in_byte (step_byte),
    .st_next (st_next),
    .run     (run_new)
  );

  // Parser state advances when a word enters the run buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: MODE_START, quote_pending: 1'b0, break_after_quote: 1'b0};
    end else if (load_buf) begin
      st <= st_next;
    end
  end

  // Skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (buf_free) skid_valid <= 1'b0;
    end else if (in_fire && !buf_free) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && in_fire && !buf_free) begin
      skid_byte <= in_byte;
    end
  end

  // Run buffer and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (load_buf) begin
      buf_valid <= (run_new.count != '0);
      idx       <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        buf_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_buf) begin
      run_buf <= run_new;
    end
  end

  `ASSERT_ALWAYS(a_run_nonempty, !out_valid || (run_buf.count != '0), "empty run shown")
  `ASSERT_ALWAYS(a_idx_in_run, !out_valid || (idx < run_buf.count), "read index past run")
  `ASSERT_ALWAYS(a_qp_mode,
                 !st.quote_pending || (st.mode == MODE_QUOTED || st.mode == MODE_DQ),
                 "pending quote outside quotes")
  `ASSERT_ALWAYS(a_baq_mode, !st.break_after_quote || (st.mode == MODE_BREAK),
                 "quote break flag outside break mode")
  `ASSERT_NEXT(a_run_continues, out_fire && !is_last, out_valid, "run cut short")

endmodule

// ===== dv/csv_empty_field_filler_unit_chk.sv =====
// Checker for the CSV empty field filler: predicts output words and compares them.
module csv_empty_field_filler_unit_chk (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       last_of_run,
  output int         errors,
  output int         pending,
  output int         words_out
);
  timeunit 1ns;
  timeprecision 1ps;
  import cefu_pkg::*;

  // One expected output word.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  out_word_t  want_q[$];
  logic [7:0] run_q[$];

  // Predicted parser state.
  mode_t pmode;
  logic  qpend;
  logic  quote_brk;

  task automatic emit(input logic [7:0] c);
    if (run_q.size() < RUN_MAX) begin
      run_q.push_back(c);
    end
  endtask

  task automatic emit_fill();
    repeat (PH_LEN) emit(CH_X);
  endtask

  // Handle one character in the current mode.
  task automatic parse_char(input logic [7:0] c);
    case (pmode)
      MODE_BREAK: begin
        if (c == CH_COMMA) begin
          // a comma right after a closing quote was already written
          if (!quote_brk) begin
            emit_fill();
            emit(CH_COMMA);
          end
          quote_brk = 1'b0;
        end else if (c == CH_QUOTE) begin
          emit(c);
          pmode = MODE_QUOTED;
          quote_brk = 1'b0;
        end else if (c == CH_NL) begin
          emit_fill();
          emit(CH_NL);
          pmode = MODE_START;
          quote_brk = 1'b0;
        end else begin
          emit(c);
          pmode = MODE_INVAL;
          quote_brk = 1'b0;
        end
      end
      MODE_INVAL: begin
        if (c == CH_COMMA) begin
          emit(c);
          pmode = MODE_BREAK;
          quote_brk = 1'b0;
        end else if (c == CH_NL) begin
          emit(CH_NL);
          pmode = MODE_START;
        end else if (c != CH_QUOTE) begin
          // stray quotes in unquoted text are dropped
          emit(c);
        end
      end
      MODE_QUOTED, MODE_DQ: begin
        if (c == CH_QUOTE) begin
          qpend = 1'b1;
        end else if (c != CH_NL) begin
          emit(c);
        end
      end
      default: begin
        if (c == CH_COMMA) begin
          emit_fill();
          emit(CH_COMMA);
          pmode = MODE_BREAK;
          quote_brk = 1'b0;
        end else if (c == CH_QUOTE) begin
          emit(c);
          pmode = MODE_QUOTED;
        end else if (c == CH_NL) begin
          emit(CH_NL);
          pmode = MODE_START;
        end else begin
          emit(c);
          pmode = MODE_INVAL;
        end
      end
    endcase
  endtask

  // Expected output run for one accepted input word.
  task automatic filler_step(input logic [7:0] c);
    run_q.delete();
    if (qpend) begin
      qpend = 1'b0;
      if (c == CH_QUOTE && (pmode == MODE_QUOTED || pmode == MODE_DQ)) begin
        // doubled quote: keep both, flip between quoted and doubled section
        emit(CH_QUOTE);
        emit(CH_QUOTE);
        if (pmode == MODE_QUOTED) begin
          pmode = MODE_DQ;
        end else begin
          pmode = MODE_QUOTED;
        end
      end else begin
        if (pmode == MODE_QUOTED) begin
          emit(CH_QUOTE);
          emit(CH_COMMA);
          pmode = MODE_BREAK;
          quote_brk = 1'b1;
        end
        parse_char(c);
      end
    end else begin
      parse_char(c);
    end
    foreach (run_q[k]) begin
      want_q.push_back('{ch: run_q[k], last: (k == run_q.size() - 1)});
    end
  endtask

  // Predict on input accepts, compare on output accepts.
  always @(posedge clk) begin : watch
    out_word_t w;
    if (rst) begin
      pmode = MODE_START;
      qpend = 1'b0;
      quote_brk = 1'b0;
      want_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        filler_step(in_byte);
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output word out_byte=%h last_of_run=%b",
                   $time, out_byte, last_of_run);
        end else begin
          w = want_q.pop_front();
          if (out_byte !== w.ch) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, w.ch, out_byte);
          end
          if (last_of_run !== w.last) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time, w.last, last_of_run);
          end
        end
      end
    end
    pending = want_q.size();
  end

endmodule

// ===== dv/csv_empty_field_filler_unit_tb.sv =====
// Testbench top for the CSV empty field filler: CSV text stimulus, stalls and verdict.
module csv_empty_field_filler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cefu_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int N_DIRECTED   = 25;
  localparam int N_TOTAL      = 310;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_of_run;

  int errors;
  int pending;
  int words_out;

  logic [7:0] text_q[$];
  logic       hold_req;
  int         hold_cnt;
  int         cycles;

  csv_empty_field_filler_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  csv_empty_field_filler_unit_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run),
    .errors     (errors),
    .pending    (pending),
    .words_out  (words_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Field character; specials are remapped to letters where they would split the field.
  function automatic logic [7:0] text_char(input bit in_quotes);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_QUOTE || (!in_quotes && (c == CH_COMMA || c == CH_NL))) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
    end
    return c;
  endfunction

  // Append one CSV line, or a short burst of noise.
  task automatic add_line();
    int nf;
    int len;
    int kind;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back(CH_COMMA);
          1:       text_q.push_back(CH_QUOTE);
          2:       text_q.push_back(CH_NL);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      nf = $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) begin
          text_q.push_back(CH_COMMA);
        end
        kind = $urandom_range(0, 9);
        if (kind >= 7) begin
          // quoted field with doubled quotes and embedded newlines
          text_q.push_back(CH_QUOTE);
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 7))
              0: begin
                text_q.push_back(CH_QUOTE);
                text_q.push_back(CH_QUOTE);
              end
              1:       text_q.push_back(CH_NL);
              default: text_q.push_back(text_char(1'b1));
            endcase
          end
          text_q.push_back(CH_QUOTE);
        end else if (kind >= 3) begin
          len = $urandom_range(1, 6);
          repeat (len) text_q.push_back(text_char(1'b0));
        end
        // otherwise the field stays empty
      end
      text_q.push_back(CH_NL);
    end
  endtask

  // Receiver: stall pattern changes now and then; one long hold-off on request.
  initial begin : receiver
    int mode_left;
    int pat;
    int phase;
    mode_left = 0;
    pat = 0;
    phase = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        pat = $urandom_range(0, 3);
        mode_left = $urandom_range(30, 120);
      end
      mode_left--;
      phase++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 159;
        out_stall <= 1'b1;
      end else begin
        case (pat)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 9) < 3);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  // Cycle limit.
  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("cycle limit of %0d reached with %0d words outstanding", LIMIT_CYCLES, pending);
    $display("csv_empty_field_filler_unit_tb: errors");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int burst_left;
    int gap;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_stall = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;

    // directed text: byte extremes, every mode and transition
    text_q = {8'h00, 8'hFF, CH_QUOTE, CH_COMMA,   // plain, stray quote, comma
              CH_COMMA, CH_NL,                    // empty field, empty last field
              CH_NL,                              // blank line
              CH_COMMA, CH_QUOTE, 8'h61, CH_NL,   // empty first field, quoted + dropped NL
              CH_QUOTE, CH_QUOTE, 8'h62,          // doubled quote into doubled section
              CH_QUOTE, 8'h63,                    // held quote dropped in doubled section
              CH_QUOTE, CH_QUOTE,                 // back to quoted
              CH_QUOTE, CH_COMMA,                 // close, comma already written
              8'h64, CH_NL,
              CH_QUOTE, CH_QUOTE, CH_NL};         // close then newline: longest run
    while (text_q.size() < N_TOTAL) add_line();

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (text_q[k]) begin
      // drain after the directed part and once mid-run
      if (k == N_DIRECTED || k == 220) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      // long receiver hold-off while words keep coming
      if (k == 110) begin
        hold_req = 1'b1;
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      in_valid <= 1'b1;
      in_byte <= text_q[k];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("sent %0d text bytes (%0d directed), checked %0d output words",
             text_q.size(), N_DIRECTED, words_out);
    $display("covered quoted, doubled-quote, empty-field and noise lines, a long hold-off, drains");
    if (errors == 0 && pending == 0) begin
      $display("csv_empty_field_filler_unit_tb: clean");
    end else begin
      $display("csv_empty_field_filler_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cefu_pkg.sv
sv/cefu_step.sv
sv/csv_empty_field_filler_unit.sv
dv/csv_empty_field_filler_unit_chk.sv
dv/csv_empty_field_filler_unit_tb.sv
